FILE: design/tcptg_pkg.sv
// ============================================================================
// tcptg_pkg
// Shared codes, widths and constants of the TCP send traffic generator.
// ============================================================================
package tcptg_pkg;

    // Bus word size in bytes and its shift
    localparam int BUS_BYTES = 64;
    localparam int BUS_SHIFT = $clog2(BUS_BYTES);

    // Field widths
    localparam int OP_W      = 2;
    localparam int SESS_W    = 16;
    localparam int LEN_W     = 16;
    localparam int ERR_W     = 8;
    localparam int CHUNK_W   = 10;
    localparam int BYTES_W   = 32;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;
    // Words per packet: ceil(65535 / BUS_BYTES), plus headroom for the count
    localparam int WORDS_W   = LEN_W - BUS_SHIFT + 1;

    localparam logic [DATA_W-1:0] FILLER_WORD = 32'hDEAD_BEEF;

    // Reset values of the configuration registers
    localparam logic [CHUNK_W-1:0] CHUNK_WORDS_RST = 10'd16;

    typedef enum logic [OP_W-1:0] {
        OP_START    = 2'd0,
        OP_RESPONSE = 2'd1,
        OP_TICK     = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHUNK_WORDS    = 2'd0,
        CFG_SESSION_NUMBER = 2'd1,
        CFG_TOTAL_BYTES    = 2'd2,
        CFG_NONE           = 2'd3
    } cfg_idx_t;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam logic [ERR_W-1:0] ERR_OK     = 8'd0;
    localparam logic [ERR_W-1:0] ERR_CLOSED = 8'd1;

endpackage

FILE: design/tcp_send_traffic_generator.sv
// ============================================================================
// tcp_send_traffic_generator
// Send side of a TCP throughput generator: issues chunked send requests and
// streams filler payload words for every granted packet.
// ============================================================================
// Path: an accepted input transaction goes through the input register, then the
// result register, to the output.
// Throughput: one input transaction per cycle while out_stall does not hold the
// output; the state update is a single pass of logic between the input register and the result register.
// Reset: rst_n clears both valid flags, the phase (idle) and the counters, and
// loads chunk_words = 16, session_number = 0, total_bytes = 0.
module tcp_send_traffic_generator
(
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcptg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcptg_pkg::BYTES_W-1:0]   cfg_data,

    // Input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tcptg_pkg::OP_W-1:0]      operation,
    input  logic [tcptg_pkg::SESS_W-1:0]    reply_session,
    input  logic [tcptg_pkg::LEN_W-1:0]     reply_length,
    input  logic [tcptg_pkg::ERR_W-1:0]     reply_error,

    // Output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            result_kind,
    output logic [tcptg_pkg::SESS_W-1:0]    request_session,
    output logic [tcptg_pkg::LEN_W-1:0]     request_length,
    output logic [tcptg_pkg::DATA_W-1:0]    payload_low,
    output logic                            payload_last
);

    import tcptg_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_WORDS = 2'd2
    } phase_t;

    // ------------------------------------------------------------------------
    // Configuration registers; the port never pushes back.
    // ------------------------------------------------------------------------
    logic [CHUNK_W-1:0] chunk_words_reg;
    logic [SESS_W-1:0]  session_number_reg;
    logic [BYTES_W-1:0] total_bytes_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_words_reg    <= CHUNK_WORDS_RST;
            session_number_reg <= '0;
            total_bytes_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CHUNK_WORDS:    chunk_words_reg    <= cfg_data[CHUNK_W-1:0];
                CFG_SESSION_NUMBER: session_number_reg <= cfg_data[SESS_W-1:0];
                CFG_TOTAL_BYTES:    total_bytes_reg    <= cfg_data;
                default:            ; // ignore writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Input register. It advances whenever the result register is free or is
    // being drained in this cycle; items that give no result still advance.
    // ------------------------------------------------------------------------
    logic               in_valid_reg;
    op_t                in_op_reg;
    logic [SESS_W-1:0]  in_sess_reg;
    logic [LEN_W-1:0]   in_len_reg;
    logic [ERR_W-1:0]   in_err_reg;
    logic               advance;

    assign advance  = in_valid_reg && (!out_valid || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_op_reg   <= op_t'(operation);
            in_sess_reg <= reply_session;
            in_len_reg  <= reply_length;
            in_err_reg  <= reply_error;
        end
    end

    // ------------------------------------------------------------------------
    // Transfer state. bytes_sent_reg counts the granted bytes and saturates at
    // 32 bits. total_bytes is compared afresh each time, so a change in the
    // middle of a transfer takes effect at the next response or last word.
    // ------------------------------------------------------------------------
    phase_t             phase_reg,        phase_next;
    logic [BYTES_W-1:0] bytes_sent_reg,   bytes_sent_next;
    logic [WORDS_W-1:0] packet_words_reg, packet_words_next;
    logic [WORDS_W-1:0] word_index_reg,   word_index_next;

    // Result computed for the item in the input register
    logic               res_fire;
    logic               res_kind;
    logic [SESS_W-1:0]  res_sess;
    logic [LEN_W-1:0]   res_len;
    logic               res_last;

    logic [LEN_W-1:0]   chunk_bytes;
    logic               sent_ahead;
    logic [BYTES_W-1:0] remain_cur;
    logic [BYTES_W-1:0] remain_sub;
    logic               grant_covers;
    logic [BYTES_W:0]   sent_sum;
    logic [BYTES_W-1:0] sent_sat;
    logic [LEN_W:0]     words_round;
    logic [WORDS_W-1:0] words_calc;
    logic [WORDS_W-1:0] word_index_inc;

    // chunk_words * BUS_BYTES fits the length field exactly
    assign chunk_bytes    = LEN_W'(chunk_words_reg) << BUS_SHIFT;
    // Bytes still owed before this grant; none once the count reaches the total
    assign sent_ahead     = bytes_sent_reg >= total_bytes_reg;
    assign remain_cur     = total_bytes_reg - bytes_sent_reg;
    assign grant_covers   = sent_ahead || (BYTES_W'(in_len_reg) >= remain_cur);
    assign remain_sub     = remain_cur - BYTES_W'(in_len_reg);
    assign sent_sum       = {1'b0, bytes_sent_reg} + (BYTES_W+1)'(in_len_reg);
    assign sent_sat       = sent_sum[BYTES_W] ? '1 : sent_sum[BYTES_W-1:0];
    assign words_round    = (LEN_W+1)'(in_len_reg) + (LEN_W+1)'(BUS_BYTES - 1);
    assign words_calc     = WORDS_W'(words_round >> BUS_SHIFT);
    assign word_index_inc = word_index_reg + WORDS_W'(1);

    always_comb
    begin
        phase_next        = phase_reg;
        bytes_sent_next   = bytes_sent_reg;
        packet_words_next = packet_words_reg;
        word_index_next   = word_index_reg;
        res_fire          = 1'b0;
        res_kind          = KIND_REQUEST;
        res_sess          = '0;
        res_len           = '0;
        res_last          = 1'b0;

        case (in_op_reg)
            OP_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    // First chunk: min(chunk bytes, total)
                    phase_next  = PH_WAIT;
                    res_fire    = 1'b1;
                    res_sess    = session_number_reg;
                    res_len     = (BYTES_W'(chunk_bytes) > total_bytes_reg) ?
                                  total_bytes_reg[LEN_W-1:0] : chunk_bytes;
                end
            end
            OP_RESPONSE:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    if (in_err_reg == ERR_OK)
                    begin
                        phase_next        = PH_WORDS;
                        bytes_sent_next   = sent_sat;
                        word_index_next   = '0;
                        // Zero length still yields one word
                        packet_words_next = (words_calc == '0) ? WORDS_W'(1) : words_calc;
                        if (!grant_covers)
                        begin
                            // Request the next chunk, clipped to what is left
                            res_fire    = 1'b1;
                            res_sess    = in_sess_reg;
                            res_len     = (BYTES_W'(chunk_bytes) < remain_sub) ?
                                          chunk_bytes : remain_sub[LEN_W-1:0];
                        end
                    end
                    else if (in_err_reg != ERR_CLOSED)
                    begin
                        // Retry the same length
                        res_fire = 1'b1;
                        res_sess = in_sess_reg;
                        res_len  = in_len_reg;
                    end
                end
            end
            OP_TICK:
            begin
                if (phase_reg == PH_WORDS)
                begin
                    res_fire = 1'b1;
                    res_kind = KIND_PAYLOAD;
                    if (word_index_inc == packet_words_reg)
                    begin
                        res_last        = 1'b1;
                        word_index_next = '0;
                        if (sent_ahead)
                        begin
                            bytes_sent_next   = '0;
                            packet_words_next = '0;
                            phase_next        = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                        end
                    end
                    else
                    begin
                        word_index_next = word_index_inc;
                    end
                end
            end
            default:
            begin
                // Unused operation code: drop
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // State and result register
    // ------------------------------------------------------------------------
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [SESS_W-1:0]  out_sess_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic               out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bytes_sent_reg   <= '0;
            packet_words_reg <= '0;
            word_index_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg        <= phase_next;
                bytes_sent_reg   <= bytes_sent_next;
                packet_words_reg <= packet_words_next;
                word_index_reg   <= word_index_next;
                out_valid_reg    <= res_fire;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_fire)
        begin
            out_kind_reg <= res_kind;
            out_sess_reg <= res_sess;
            out_len_reg  <= res_len;
            out_last_reg <= res_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = out_kind_reg;
    assign request_session = out_sess_reg;
    assign request_length  = out_len_reg;
    assign payload_low     = (out_kind_reg == KIND_PAYLOAD) ? FILLER_WORD : '0;
    assign payload_last    = out_last_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_packet_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_WORDS |-> packet_words_reg != '0)
        else $error("word output with an empty packet");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_WORDS |-> word_index_reg < packet_words_reg)
        else $error("word index past packet length");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> word_index_reg == '0 && packet_words_reg == '0)
        else $error("idle with stale packet counters");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !advance)
        else $error("result register overwritten while stalled");

    a_last_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_fire && res_last |=> phase_reg != PH_WORDS)
        else $error("still in word output after last word");

endmodule
